FILE: rtl/alss_pkg.sv
// Shared types and constants for the addressable LED strip serializer.
// Used by alss_pixel_store and addressable_led_strip_serializer; no dependencies.
package alss_pkg;

  localparam int MAX_PIXELS_DEF = 256;

  localparam int TICK_W   = 15;
  localparam int LEN_CFG_W = 9;
  localparam int LEVEL_W  = 8;
  localparam int PIXEL_W  = 3 * LEVEL_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = TICK_W;

  localparam logic [TICK_W-1:0]    ZERO_HIGH_RST = TICK_W'(14);
  localparam logic [TICK_W-1:0]    ZERO_LOW_RST  = TICK_W'(32);
  localparam logic [TICK_W-1:0]    ONE_HIGH_RST  = TICK_W'(32);
  localparam logic [TICK_W-1:0]    ONE_LOW_RST   = TICK_W'(24);
  localparam logic [LEN_CFG_W-1:0] STRIP_LEN_RST = LEN_CFG_W'(25);

  typedef logic [PIXEL_W-1:0] pixel_word_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_REFRESH = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ZERO_LOW  = 3'd1,
    CFG_ONE_HIGH  = 3'd2,
    CFG_ONE_LOW   = 3'd3,
    CFG_STRIP_LEN = 3'd4
  } cfg_index_t;

  // Byte of a pixel word in send order: green, red, blue.
  function automatic logic [LEVEL_W-1:0] color_byte(input pixel_word_t word,
                                                    input logic [1:0] which);
    logic [LEVEL_W-1:0] b;
    unique case (which)
      2'd0:    b = word[3*LEVEL_W-1:2*LEVEL_W];
      2'd1:    b = word[2*LEVEL_W-1:LEVEL_W];
      2'd2:    b = word[LEVEL_W-1:0];
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

FILE: rtl/alss_pixel_store.sv
// Pixel color memory with per-entry written flags for the LED strip serializer.
// Depends on alss_pkg. One write port, one registered read port; clear drops all flags.
module alss_pixel_store #(
  parameter int MAX_PIXELS = alss_pkg::MAX_PIXELS_DEF,
  parameter int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  alss_pkg::pixel_word_t wr_word,
  input  logic                 clear,
  input  logic [ADDR_W-1:0]    rd_addr,
  output alss_pkg::pixel_word_t rd_word,
  output logic                 rd_written
);
  import alss_pkg::*;

  pixel_word_t             mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0]   written_r;
  pixel_word_t             rd_word_r;
  logic                    rd_written_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (clear) begin
        written_r <= '0;
      end else if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      rd_written_r <= written_r[rd_addr] & ~clear;
    end
  end

  assign rd_word    = rd_word_r;
  assign rd_written = rd_written_r;

endmodule

FILE: rtl/addressable_led_strip_serializer.sv
// Top level of the addressable LED strip serializer: command stream in, line samples out.
// Depends on alss_pkg and alss_pixel_store.
//
// Usage:
//   in_* carries one command per beat: tick, set pixel, refresh, or clear and refresh.
//   in_tuser holds the opcode; in_tdata holds pixel index and red, green, blue levels.
//   out_* returns one beat per command: line level, busy flag and status in out_tdata,
//   with out_tlast high on the tick that ends the last bit of a frame.
//   Every tick beat is one waveform step; bytes go out green, red, blue, MSB first.
//   A beat passes the input register, one pass of next-state logic and the result
//   register; one beat is taken every cycle while the receiver keeps out_tready high.
//   The pixel memory is read at the pixel the sequencer moves to, so its registered
//   read port sets no extra delay. A stalled receiver holds the result register; one
//   more beat waits in the input register and in_tready drops until the result is taken.
//   Reset (rst_n low, synchronous) loads the default bit timings and strip length,
//   drops all pixel written flags, so unwritten pixels send as zero, and ends any frame.
//   Configuration writes on cfg_* take effect at once; the user must make them while
//   the block is idle, and the block itself does not enforce this.
module addressable_led_strip_serializer #(
  parameter int MAX_PIXELS = alss_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,  // pixel_index, red, green, blue
  input  logic [1:0]                      in_tuser,  // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata, // data_line, busy_res, status, zero pad
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [alss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import alss_pkg::*;

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int LW     = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_PIXELS);

  // configuration
  logic [TICK_W-1:0]    zero_high_r, zero_low_r, one_high_r, one_low_r;
  logic [LEN_CFG_W-1:0] strip_len_r;

  // input register
  logic                 in_vld_r;
  opcode_t              op_r;
  logic [LEVEL_W-1:0]   idx_r, red_r, green_r, blue_r;

  // result register
  logic                 out_vld_r, out_line_r, out_busy_r, out_done_r;
  status_t              out_status_r;
  logic                 line_nxt, busy_nxt, done_nxt;
  status_t              status_nxt;

  // sequencer state
  logic [CNT_W-1:0]     pix_r, pix_nxt;
  logic [1:0]           cbyte_r, cbyte_nxt;
  logic [2:0]           bit_r, bit_nxt;
  logic                 high_r, high_nxt;
  logic [TICK_W-1:0]    ticks_r, ticks_nxt;
  logic                 sending_r, sending_nxt;

  logic                 fire;
  logic [LW-1:0]        len;
  logic [LW:0]          pix_inc;
  logic [LW-1:0]        idx_ext;
  logic [1:0]           cbyte_inc;
  logic [LEVEL_W-1:0]   cur_byte;
  logic                 cur_bit;
  logic [TICK_W-1:0]    limit;
  logic [TICK_W-1:0]    ticks_inc;
  logic                 wr_en, clear;
  pixel_word_t          rd_word;
  logic                 rd_written;

  assign fire      = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | fire;

  assign len = (LW'(strip_len_r) > MAX_L) ? MAX_L : LW'(strip_len_r);
  assign idx_ext = LW'(idx_r);

  assign cur_byte  = color_byte(rd_word, cbyte_r) & {LEVEL_W{rd_written}};
  assign cur_bit   = cur_byte[bit_r];
  assign limit     = high_r ? at_least_one(cur_bit ? one_high_r : zero_high_r)
                            : at_least_one(cur_bit ? one_low_r : zero_low_r);
  assign ticks_inc = ticks_r + TICK_W'(1);
  assign cbyte_inc = cbyte_r + 2'd1;

  always_comb begin
    pix_nxt     = pix_r;
    cbyte_nxt   = cbyte_r;
    bit_nxt     = bit_r;
    high_nxt    = high_r;
    ticks_nxt   = ticks_r;
    sending_nxt = sending_r;
    line_nxt    = 1'b0;
    busy_nxt    = 1'b0;
    done_nxt    = 1'b0;
    status_nxt  = ST_OK;
    wr_en       = 1'b0;
    clear       = 1'b0;
    pix_inc     = '0;
    if (fire) begin
      if (op_r == OP_TICK) begin
        if (sending_r) begin
          line_nxt  = high_r;
          busy_nxt  = 1'b1;
          ticks_nxt = ticks_inc;
          if (ticks_inc >= limit) begin
            ticks_nxt = '0;
            if (high_r) begin
              high_nxt = 1'b0;
            end else if (bit_r != 3'd0) begin
              bit_nxt  = bit_r - 3'd1;
              high_nxt = 1'b1;
            end else begin
              bit_nxt = 3'd7;
              if (cbyte_inc == 2'd3) begin
                cbyte_nxt = 2'd0;
                pix_inc   = (LW+1)'(pix_r) + (LW+1)'(1);
                if (pix_inc >= (LW+1)'(len)) begin
                  sending_nxt = 1'b0;
                  done_nxt    = 1'b1;
                  high_nxt    = 1'b0;
                  pix_nxt     = '0;
                end else begin
                  pix_nxt  = CNT_W'(pix_inc);
                  high_nxt = 1'b1;
                end
              end else begin
                cbyte_nxt = cbyte_inc;
                high_nxt  = 1'b1;
              end
            end
          end
        end
      end else if (sending_r) begin
        line_nxt   = high_r;
        busy_nxt   = 1'b1;
        status_nxt = ST_BUSY;
      end else if (op_r == OP_SET) begin
        if (idx_ext < len && idx_ext < MAX_L) begin
          wr_en = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end else begin
        clear = (op_r == OP_CLEAR);
        if (len != '0) begin
          sending_nxt = 1'b1;
          busy_nxt    = 1'b1;
          pix_nxt     = '0;
          cbyte_nxt   = 2'd0;
          bit_nxt     = 3'd7;
          ticks_nxt   = '0;
          high_nxt    = 1'b1;
        end
      end
    end
  end

  alss_pixel_store #(
    .MAX_PIXELS(MAX_PIXELS),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (ADDR_W'(idx_r)),
    .wr_word   ({green_r, red_r, blue_r}),
    .clear     (clear),
    .rd_addr   (ADDR_W'(pix_nxt)),
    .rd_word   (rd_word),
    .rd_written(rd_written)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= ZERO_HIGH_RST;
      zero_low_r  <= ZERO_LOW_RST;
      one_high_r  <= ONE_HIGH_RST;
      one_low_r   <= ONE_LOW_RST;
      strip_len_r <= STRIP_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ZERO_HIGH: zero_high_r <= cfg_wdata;
        CFG_ZERO_LOW:  zero_low_r  <= cfg_wdata;
        CFG_ONE_HIGH:  one_high_r  <= cfg_wdata;
        CFG_ONE_LOW:   one_low_r   <= cfg_wdata;
        CFG_STRIP_LEN: strip_len_r <= cfg_wdata[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      op_r    <= opcode_t'(in_tuser);
      idx_r   <= in_tdata[7:0];
      red_r   <= in_tdata[15:8];
      green_r <= in_tdata[23:16];
      blue_r  <= in_tdata[31:24];
    end
    if (fire) begin
      out_line_r   <= line_nxt;
      out_busy_r   <= busy_nxt;
      out_done_r   <= done_nxt;
      out_status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pix_r     <= '0;
      cbyte_r   <= 2'd0;
      bit_r     <= 3'd7;
      high_r    <= 1'b0;
      ticks_r   <= '0;
      sending_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      pix_r     <= pix_nxt;
      cbyte_r   <= cbyte_nxt;
      bit_r     <= bit_nxt;
      high_r    <= high_nxt;
      ticks_r   <= ticks_nxt;
      sending_r <= sending_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_status_r, out_busy_r, out_line_r};
  assign out_tlast  = out_done_r;

endmodule
